### design/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg
// Shared types and constants of the multiple-angle sine/cosine pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scm_pkg;

	localparam int WORK_FRAC            = 52;
	localparam int ANGLE_FRAC_BITS_DEF  = 28;
	localparam int RESULT_FRAC_BITS_DEF = 30;
	localparam int N_SERIES             = 6;
	localparam int N_BYPASS             = 4;
	localparam int N_T8                 = 3;

	typedef logic signed [63:0] scm_word_t;

	// Value that is multiplied in a cell and the factor that travels with it.
	typedef struct packed {
		scm_word_t v;
		scm_word_t f;
	} scm_tok_t;

	localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
	localparam logic [29:0] INV2PI_Q32 = 30'h28BE60DC;

	localparam scm_word_t WONE    = scm_word_t'(64'd1 << WORK_FRAC);
	localparam scm_word_t PI4_W   = scm_word_t'((PI_Q60 + (64'd1 << 9)) >> 10);
	localparam scm_word_t PI16_W  = scm_word_t'((PI_Q60 + (64'd1 << 11)) >> 12);
	localparam scm_word_t PI8_Q32 = scm_word_t'((PI_Q60 + (64'd1 << 30)) >> 31);

	localparam scm_word_t R24        = scm_word_t'(((64'd1 << WORK_FRAC) + 64'd12) / 64'd24);
	localparam scm_word_t R720       = scm_word_t'(((64'd1 << WORK_FRAC) + 64'd360) / 64'd720);
	localparam scm_word_t R40320     =
		scm_word_t'(((64'd1 << WORK_FRAC) + 64'd20160) / 64'd40320);
	localparam scm_word_t R3628800   =
		scm_word_t'(((64'd1 << WORK_FRAC) + 64'd1814400) / 64'd3628800);
	localparam scm_word_t R479001600 =
		scm_word_t'(((64'd1 << WORK_FRAC) + 64'd239500800) / 64'd479001600);

	// Horner addends of the cosine series, highest order first.
	localparam scm_word_t SERIES_ADD [N_SERIES] = '{
		-R3628800, R40320, -R720, R24, -(WONE / 2), WONE
	};

	// Horner addends of the eighth-order Chebyshev polynomial in c^2.
	localparam scm_word_t T8_ADD [N_T8] = '{
		160 * WONE, -32 * WONE, WONE
	};

endpackage

### design/scm_reduce.sv
// ----------------------------------------------------------------------------
// scm_reduce
// Angle reduction: turn count and reduced angle, four pipeline stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scm_reduce #(
	parameter int ANGLE_FRAC_BITS = scm_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic                    action,
	input  logic signed [31:0]      angle,
	output logic                    out_valid,
	output scm_pkg::scm_word_t      x
);
	import scm_pkg::*;

	localparam int KW  = (33 - ANGLE_FRAC_BITS > 4) ? 33 - ANGLE_FRAC_BITS : 4;
	localparam int XSH = WORK_FRAC - ANGLE_FRAC_BITS - 3;
	localparam logic [31:0] PI4_LO = PI4_W[31:0];
	localparam logic [31:0] PI4_HI = PI4_W[63:32];

	logic                   vld_s1, vld_s2, vld_s3, vld_s4;
	logic                   act_s1, act_s2, act_s3;
	logic signed [31:0]     a_s1, a_s2, a_s3;
	logic signed [61:0]     prod_s1;
	logic signed [KW-1:0]   k_s2;
	logic signed [KW+32:0]  plo_s3, phi_s3;
	scm_word_t              x_s4;

	logic signed [61:0]     prod_w;
	scm_word_t              u_w, k_w, kp_w, xw_w;
	logic signed [KW+32:0]  plo_w, phi_w;

	assign prod_w = angle * $signed({1'b0, INV2PI_Q32});
	assign u_w    = scm_word_t'(prod_s1 >>> ANGLE_FRAC_BITS) + PI8_Q32;
	// The turn count truncates toward zero.
	assign k_w    = (u_w >= 0) ? (u_w >>> 32) : -((-u_w) >>> 32);
	assign plo_w  = k_s2 * $signed({1'b0, PI4_LO});
	assign phi_w  = k_s2 * $signed({1'b0, PI4_HI});
	assign kp_w   = scm_word_t'(plo_s3) + (scm_word_t'(phi_s3) <<< 32);
	assign xw_w   = (scm_word_t'(a_s3) <<< XSH) - kp_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_w;
			a_s1    <= angle;
			act_s1  <= action;
			k_s2    <= k_w[KW-1:0];
			a_s2    <= a_s1;
			act_s2  <= act_s1;
			plo_s3  <= plo_w;
			phi_s3  <= phi_w;
			a_s3    <= a_s2;
			act_s3  <= act_s2;
			// Sine is the cosine of the angle less a quarter turn.
			x_s4    <= act_s3 ? xw_w : xw_w - PI16_W;
		end
	end

	assign out_valid = vld_s4;
	assign x         = x_s4;

endmodule

### design/scm_cell.sv
// ----------------------------------------------------------------------------
// scm_cell
// One Horner cell: v_out = addend + round(v * f), or v itself when bypassed, four pipeline stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scm_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  scm_pkg::scm_tok_t   tok_in,
	input  scm_pkg::scm_word_t  addend,
	input  logic                bypass,
	output logic                out_valid,
	output scm_pkg::scm_tok_t   tok_out
);
	import scm_pkg::*;

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	scm_tok_t           tok_s1, tok_s2, tok_s3, tok_s4;
	logic               neg_s1, neg_s2, neg_s3;
	logic [63:0]        ua_s1, ub_s1;
	logic [63:0]        p00_s2, p01_s2, p10_s2, p11_s2;
	logic [62:0]        q_s3;

	logic [127:0]       sum_w;
	scm_word_t          mag_w, r_w;

	// Magnitude product with 2^-52 rounding, halves away from zero.
	assign sum_w = {64'd0, p00_s2} + {32'd0, p01_s2, 32'd0} + {32'd0, p10_s2, 32'd0}
		+ {p11_s2, 64'd0} + (128'd1 << (WORK_FRAC - 1));
	assign mag_w = {1'b0, q_s3};
	assign r_w   = (neg_s3 ? -mag_w : mag_w) + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ua_s1    <= tok_in.v[63] ? 64'd0 - tok_in.v : tok_in.v;
			ub_s1    <= tok_in.f[63] ? 64'd0 - tok_in.f : tok_in.f;
			neg_s1   <= tok_in.v[63] ^ tok_in.f[63];
			tok_s1   <= tok_in;
			p00_s2   <= ua_s1[31:0] * ub_s1[31:0];
			p01_s2   <= ua_s1[31:0] * ub_s1[63:32];
			p10_s2   <= ua_s1[63:32] * ub_s1[31:0];
			p11_s2   <= ua_s1[63:32] * ub_s1[63:32];
			neg_s2   <= neg_s1;
			tok_s2   <= tok_s1;
			q_s3     <= sum_w[WORK_FRAC+62:WORK_FRAC];
			neg_s3   <= neg_s2;
			tok_s3   <= tok_s2;
			tok_s4.v <= bypass ? tok_s3.v : r_w;
			tok_s4.f <= tok_s3.f;
		end
	end

	assign out_valid = vld_s4;
	assign tok_out   = tok_s4;

endmodule

### design/sine_cosine_multiple_angle_core.sv
// ----------------------------------------------------------------------------
// sine_cosine_multiple_angle_core
// Sine or cosine of a Q3.28 angle, returned as Q1.30 saturated to +/-1.
// The block takes one angle per clock while the row is not held, and each result
// passes through angle reduction, eleven multiply cells in a row (the square
// of the reduced angle, six cosine series cells, the square of the cosine and
// three Chebyshev cells), and the output register. In the quick mode the first
// four series cells pass their value through unchanged but keep their
// registers, so results take the same path. A result waiting at the output
// holds the whole row until it is taken; the input is ready whenever the
// output register is empty or being read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sine_cosine_multiple_angle_core #(
	parameter int ANGLE_FRAC_BITS  = scm_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int RESULT_FRAC_BITS = scm_pkg::RESULT_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic signed [31:0] angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result,
	input  logic               cfg_we,
	input  logic               cfg_wdata
);
	import scm_pkg::*;

	localparam int OSH = WORK_FRAC - RESULT_FRAC_BITS;
	localparam scm_word_t RND   = scm_word_t'(64'd1 << (OSH - 1));
	localparam scm_word_t R_MAX = 64'sd2147483647;
	localparam scm_word_t R_MIN = -64'sd2147483648;
	localparam logic signed [32:0] RLIM_HI =
		(RESULT_FRAC_BITS > 30) ? 33'sd2147483647 : (33'sd1 <<< RESULT_FRAC_BITS);
	localparam logic signed [32:0] RLIM_LO =
		(RESULT_FRAC_BITS > 30) ? -33'sd2147483648 : -(33'sd1 <<< RESULT_FRAC_BITS);

	logic        precision_q;
	logic        res_vld_q;
	logic signed [31:0] result_q;
	logic        en;

	logic        x_vld;
	scm_word_t   x;
	logic        sq_vld;
	scm_tok_t    sq_tok;
	logic        ser_vld [N_SERIES+1];
	scm_tok_t    ser_tok [N_SERIES+1];
	logic        cc_vld;
	scm_tok_t    cc_tok;
	logic        t_vld [N_T8+1];
	scm_tok_t    t_tok [N_T8+1];

	scm_word_t   sat_w, rnd_w, clamp_w;

	assign en       = !res_vld_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			precision_q <= 1'b0;
		end else if (cfg_we) begin
			precision_q <= cfg_wdata;
		end
	end

	scm_reduce #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.action   (action),
		.angle    (angle),
		.out_valid(x_vld),
		.x        (x)
	);

	scm_cell u_sq (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (x_vld),
		.tok_in   ('{v: x, f: x}),
		.addend   ('0),
		.bypass   (1'b0),
		.out_valid(sq_vld),
		.tok_out  (sq_tok)
	);

	assign ser_vld[0] = sq_vld;
	assign ser_tok[0] = '{v: (precision_q ? R24 : R479001600), f: sq_tok.v};

	for (genvar i = 0; i < N_SERIES; i++) begin : g_series
		scm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (ser_vld[i]),
			.tok_in   (ser_tok[i]),
			.addend   (SERIES_ADD[i]),
			.bypass   (precision_q && (i < N_BYPASS)),
			.out_valid(ser_vld[i+1]),
			.tok_out  (ser_tok[i+1])
		);
	end

	scm_cell u_csq (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (ser_vld[N_SERIES]),
		.tok_in   ('{v: ser_tok[N_SERIES].v, f: ser_tok[N_SERIES].v}),
		.addend   ('0),
		.bypass   (1'b0),
		.out_valid(cc_vld),
		.tok_out  (cc_tok)
	);

	assign t_vld[0] = cc_vld;
	assign t_tok[0] = '{v: (cc_tok.v <<< 7) - 256 * WONE, f: cc_tok.v};

	for (genvar j = 0; j < N_T8; j++) begin : g_t8
		scm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (t_vld[j]),
			.tok_in   (t_tok[j]),
			.addend   (T8_ADD[j]),
			.bypass   (1'b0),
			.out_valid(t_vld[j+1]),
			.tok_out  (t_tok[j+1])
		);
	end

	always_comb begin
		if (t_tok[N_T8].v > WONE) begin
			sat_w = WONE;
		end else if (t_tok[N_T8].v < -WONE) begin
			sat_w = -WONE;
		end else begin
			sat_w = t_tok[N_T8].v;
		end
		rnd_w = (sat_w + RND) >>> OSH;
		if (rnd_w > R_MAX) begin
			clamp_w = R_MAX;
		end else if (rnd_w < R_MIN) begin
			clamp_w = R_MIN;
		end else begin
			clamp_w = rnd_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (en) begin
			res_vld_q <= t_vld[N_T8];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= clamp_w[31:0];
		end
	end

	assign out_valid = res_vld_q;
	assign result    = result_q;

	// A delivered result never leaves the saturated range.
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed({result[31], result}) <= RLIM_HI
			&& $signed({result[31], result}) >= RLIM_LO))
		else $error("result outside the saturated range");

	// A new result appears only when the row was free to advance just before it rises.
	a_rise_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_ready))
		else $error("result appeared while the pipeline was held");

endmodule
